FILE: src/cse_pkg.sv
`default_nettype none

package cse_pkg;

  // Payload bytes that one frame can carry; a larger byte count is clamped to this.
  localparam int PAYLOAD_BYTES = 8;

  // Width of the gathered payload word and of the extracted field.
  localparam int WORD_W = 64;

  // Number of register stages between an accepted word and its result.
  localparam int PIPE_DEPTH = 5;

  // Bits of limit_enable.
  localparam int LIMIT_MIN_BIT = 0;
  localparam int LIMIT_MAX_BIT = 1;

  // Saturation bounds of the scaled value.
  localparam logic [63:0] SCALED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SCALED_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    STATUS_OK,
    STATUS_NO_DATA,
    STATUS_BEYOND_DATA,
    STATUS_OUTSIDE_WINDOW,
    STATUS_BELOW_MIN,
    STATUS_ABOVE_MAX
  } status_t;

  typedef enum logic [2:0] {
    REG_FIELD_START,
    REG_BIT_LENGTH,
    REG_MSB_FIRST,
    REG_RESOLUTION,
    REG_OFFSET,
    REG_MINIMUM,
    REG_MAXIMUM,
    REG_LIMIT_ENABLE
  } reg_index_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [3:0] byte_count;
  } item_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic signed [63:0] scaled_value;
    logic               saturated;
    status_t            status;
  } result_t;

endpackage

`default_nettype wire

FILE: src/can_signal_extract_scale.sv
`default_nettype none

// CAN signal decoder: pulls one bit field out of a CAN payload, scales it and
// checks it against optional limits.
//
// Input channel: a word (eight payload bytes and a byte count) is taken on a
// rising edge where start is high and busy is low. busy never rises, so a new
// word may be given in every cycle.
//
// Output channel: each result word appears on result for exactly one cycle,
// marked by done, once its input has passed through the stages listed below.
// The receiver cannot hold results off; one result per cycle is sustained.
// The five stages are: field extraction, two 32x32 partial products, product
// merge, signed offset add with saturation, and the limit compare.
//
// Configuration: cfg_valid/cfg_ready write cfg_data into the register chosen
// by cfg_index. cfg_ready is always high. Registers must only be changed while
// no word is in flight, since all stages but the product merge read them directly.
//
// Reset (rst, synchronous) empties the pipeline and loads the register reset
// values: start bit 0, length 8, little-endian, resolution 1.0, no limits.
module can_signal_extract_scale
  import cse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire reg_index_t  cfg_index,
  input  wire logic [47:0] cfg_data
);

  // Configuration registers.
  logic [5:0]         field_start;
  logic [6:0]         bit_length;
  logic               msb_first;
  logic [31:0]        resolution;
  logic [47:0]        offset;
  logic [47:0]        minimum;
  logic [47:0]        maximum;
  logic [1:0]         limit_enable;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_start  <= '0;
      bit_length   <= 7'd8;
      msb_first    <= 1'b0;
      resolution   <= 32'd65536;
      offset       <= '0;
      minimum      <= '0;
      maximum      <= '0;
      limit_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIELD_START:  field_start  <= cfg_data[5:0];
        REG_BIT_LENGTH:   bit_length   <= cfg_data[6:0];
        REG_MSB_FIRST:    msb_first    <= cfg_data[0];
        REG_RESOLUTION:   resolution   <= cfg_data[31:0];
        REG_OFFSET:       offset       <= cfg_data;
        REG_MINIMUM:      minimum      <= cfg_data;
        REG_MAXIMUM:      maximum      <= cfg_data;
        REG_LIMIT_ENABLE: limit_enable <= cfg_data[1:0];
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: data checks and field extraction.
  // ---------------------------------------------------------------------------
  logic [3:0]        byte_cnt;
  logic [7:0]        field_end;
  logic [7:0]        data_bits;
  logic              data_err;
  status_t           err_status;
  logic [WORD_W-1:0] le_word;
  logic [WORD_W-1:0] be_word;
  logic [WORD_W-1:0] sel_word;
  logic [6:0]        be_shift;
  logic [5:0]        shift_amt;
  logic [WORD_W-1:0] field_mask;
  logic [WORD_W-1:0] raw_next;

  assign byte_cnt  = (item.byte_count > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES)
                                                             : item.byte_count;
  assign field_end = {2'b00, field_start} + {1'b0, bit_length};
  assign data_bits = {1'b0, byte_cnt, 3'b000};

  always_comb begin
    data_err   = 1'b1;
    err_status = STATUS_OK;
    if (byte_cnt == 4'd0) begin
      err_status = STATUS_NO_DATA;
    end else if (bit_length == 7'd0 || field_end > data_bits) begin
      err_status = STATUS_BEYOND_DATA;
    end else begin
      data_err = 1'b0;
    end
  end

  // Bytes beyond the count need no masking: a valid field never reaches them.
  assign le_word = {item.byte7, item.byte6, item.byte5, item.byte4,
                    item.byte3, item.byte2, item.byte1, item.byte0};
  assign be_word = {item.byte0, item.byte1, item.byte2, item.byte3,
                    item.byte4, item.byte5, item.byte6, item.byte7};

  // In big-endian order the field sits with its MSB at word bit 63 - field_start,
  // so its LSB is 64 - field_start - bit_length, which fits six bits when valid.
  assign be_shift   = 7'd64 - {1'b0, field_start} - bit_length;
  assign shift_amt  = msb_first ? be_shift[5:0] : field_start;
  assign sel_word   = msb_first ? be_word : le_word;
  assign field_mask = {WORD_W{1'b1}} >> (7'd64 - bit_length);
  assign raw_next   = data_err ? '0 : ((sel_word >> shift_amt) & field_mask);

  logic              s1_valid;
  logic [WORD_W-1:0] s1_raw;
  logic              s1_err;
  status_t           s1_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_raw    <= raw_next;
    s1_err    <= data_err;
    s1_status <= err_status;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: two 32x32 partial products of raw times |resolution|.
  // ---------------------------------------------------------------------------
  logic [31:0] res_mag;

  assign res_mag = resolution[31] ? (~resolution + 32'd1) : resolution;

  logic        s2_valid;
  logic [63:0] s2_p0;
  logic [63:0] s2_p1;
  logic        s2_neg;
  logic [63:0] s2_raw;
  logic        s2_err;
  status_t     s2_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_p0     <= s1_raw[31:0] * res_mag;
    s2_p1     <= s1_raw[63:32] * res_mag;
    s2_neg    <= resolution[31];
    s2_raw    <= s1_raw;
    s2_err    <= s1_err;
    s2_status <= s1_status;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: merge the partial products into the 96-bit magnitude.
  // ---------------------------------------------------------------------------
  logic        s3_valid;
  logic [95:0] s3_prod;
  logic        s3_neg;
  logic [63:0] s3_raw;
  logic        s3_err;
  status_t     s3_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_prod   <= {32'd0, s2_p0} + {s2_p1, 32'd0};
    s3_neg    <= s2_neg;
    s3_raw    <= s2_raw;
    s3_err    <= s2_err;
    s3_status <= s2_status;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: apply the sign, add the offset and saturate to 64 bits.
  // ---------------------------------------------------------------------------
  logic [97:0] off_ext;
  logic [97:0] prod_ext;
  logic [97:0] sum;
  logic        fits;
  logic [63:0] value_next;

  assign off_ext  = {{50{offset[47]}}, offset};
  assign prod_ext = {2'b00, s3_prod};
  assign sum      = s3_neg ? (off_ext - prod_ext) : (off_ext + prod_ext);
  assign fits     = (sum[97:63] == '0) || (sum[97:63] == '1);
  assign value_next = fits ? sum[63:0] : (sum[97] ? SCALED_MIN : SCALED_MAX);

  logic        s4_valid;
  logic [63:0] s4_value;
  logic        s4_sat;
  logic [63:0] s4_raw;
  logic        s4_err;
  status_t     s4_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_value  <= value_next;
    s4_sat    <= !fits;
    s4_raw    <= s3_raw;
    s4_err    <= s3_err;
    s4_status <= s3_status;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: limit check and output register.
  // ---------------------------------------------------------------------------
  logic signed [63:0] value_s;
  logic signed [63:0] min_s;
  logic signed [63:0] max_s;
  status_t            limit_status;
  result_t            result_next;

  assign value_s = $signed(s4_value);
  assign min_s   = $signed({{16{minimum[47]}}, minimum});
  assign max_s   = $signed({{16{maximum[47]}}, maximum});

  always_comb begin
    limit_status = STATUS_OK;
    if (limit_enable[LIMIT_MIN_BIT] && limit_enable[LIMIT_MAX_BIT]) begin
      if (min_s >= value_s || value_s >= max_s) begin
        limit_status = STATUS_OUTSIDE_WINDOW;
      end
    end else if (limit_enable[LIMIT_MIN_BIT] && value_s < min_s) begin
      limit_status = STATUS_BELOW_MIN;
    end else if (limit_enable[LIMIT_MAX_BIT] && value_s > max_s) begin
      limit_status = STATUS_ABOVE_MAX;
    end
  end

  always_comb begin
    if (s4_err) begin
      result_next.raw_value    = '0;
      result_next.scaled_value = '0;
      result_next.saturated    = 1'b0;
      result_next.status       = s4_status;
    end else begin
      result_next.raw_value    = s4_raw;
      result_next.scaled_value = value_s;
      result_next.saturated    = s4_sat;
      result_next.status       = limit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef NO_ASSERTIONS
  // Every accepted word yields its result a fixed number of cycles later.
  assert property (@(posedge clk) disable iff (rst)
                   (start && !busy) |-> ##5 done)
    else $error("accepted word did not produce a result after five cycles");

  // A clamped value must sit on one of the two 64-bit bounds.
  assert property (@(posedge clk) disable iff (rst)
                   (done && result.saturated) |->
                   (result.scaled_value == SCALED_MIN ||
                    result.scaled_value == SCALED_MAX))
    else $error("saturated result is not at a 64-bit bound");

  // Data errors must clear every value field.
  assert property (@(posedge clk) disable iff (rst)
                   (done && (result.status == STATUS_NO_DATA ||
                             result.status == STATUS_BEYOND_DATA)) |->
                   (result.raw_value == '0 && result.scaled_value == '0 &&
                    !result.saturated))
    else $error("data error result carries nonzero value fields");
`endif

endmodule

`default_nettype wire
